@@ rtl/rcst_pkg.sv @@
// Shared types, command codes and constants of the column raycaster.
package rcst_pkg;

    // Field widths
    localparam int COL_W    = 10;
    localparam int POS_W    = 21;
    localparam int ANG_W    = 16;
    localparam int DEPTH_W  = 22;
    localparam int D_W      = 23;   // march distance, one step past max depth
    localparam int ACC_W    = 40;   // signed Q.31 position accumulator
    localparam int DIVD_W   = 40;
    localparam int DIVS_W   = 23;
    localparam int PROD_W   = 36;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 22;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_OF_VIEW = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEPTH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MARCH_STEP    = 3'd4;

    // Register reset values
    localparam logic [9:0]  RST_SCREEN_WIDTH  = 10'd320;
    localparam logic [7:0]  RST_SCREEN_HEIGHT = 8'd240;
    localparam logic [15:0] RST_FIELD_OF_VIEW = 16'd4096;
    localparam logic [21:0] RST_MAX_DEPTH     = 22'd1048576;
    localparam logic [15:0] RST_MARCH_STEP    = 16'd655;

    // Quarter-wave sine polynomial coefficients, Q16
    localparam logic signed [17:0] POLY_A = 18'sd102944;
    localparam logic signed [17:0] POLY_B = 18'sd42048;
    localparam logic signed [17:0] POLY_C = 18'sd4640;

    localparam logic [0:0] REQ_LOAD = 1'b0;
    localparam logic [0:0] REQ_CAST = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [4:0]  row_index;
        logic [31:0] row_bits;
        logic [20:0] pos_x;
        logic [20:0] pos_y;
        logic [15:0] view_angle;
        logic [9:0]  column;
    } t_in_item;

    typedef struct packed {
        logic [9:0]        out_column;
        logic [21:0]       distance;
        logic              wall_hit;
        logic signed [7:0] ceiling_row;
        logic [8:0]        floor_row;
        logic [15:0]       texture_u;
    } t_out_item;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CT_MUL, ST_CT_DIV, ST_CT_WAIT, ST_ANGLE, ST_SZ,
        ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_INC_X, ST_INC_Y, ST_INIT,
        ST_MARCH, ST_CL_DIV, ST_CL_WAIT, ST_FINISH
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_CT_MUL, OP_CT_DIV, OP_ANGLE, OP_SZ, OP_P1, OP_P2,
        OP_P3, OP_P4, OP_P5, OP_INC_X, OP_INC_Y, OP_INIT, OP_MARCH,
        OP_CL_DIV, OP_FINISH
    } t_dp_op;

    typedef struct packed {
        logic   accept;
        logic   cos_sel;
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic march_done;
        logic zero_depth;
        logic out_free;
    } t_dp_status;

endpackage

@@ rtl/rcst_div.sv @@
// Restoring divider, one quotient bit per cycle.
module rcst_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [rcst_pkg::DIVD_W-1:0]    i_dividend,
    input  logic [rcst_pkg::DIVS_W-1:0]    i_divisor,
    output logic                           o_done,
    output logic [rcst_pkg::DIVD_W-1:0]    o_quotient
);
    localparam int CNT_W = $clog2(rcst_pkg::DIVD_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(rcst_pkg::DIVD_W - 1);

    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [CNT_W-1:0]              r_cnt, n_cnt;
    logic [rcst_pkg::DIVS_W:0]     r_rem, n_rem;
    logic [rcst_pkg::DIVD_W-1:0]   r_quo, n_quo;
    logic [rcst_pkg::DIVS_W-1:0]   r_div;
    logic [rcst_pkg::DIVS_W:0]     rem_sh;
    logic [rcst_pkg::DIVS_W+1:0]   diff;

    // Shift in one dividend bit, subtract where it fits
    always_comb begin
        rem_sh = {r_rem[rcst_pkg::DIVS_W-1:0], r_quo[rcst_pkg::DIVD_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, r_div};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
        end else if (r_busy) begin
            n_rem = diff[rcst_pkg::DIVS_W+1] ? rem_sh : diff[rcst_pkg::DIVS_W:0];
            n_quo = {r_quo[rcst_pkg::DIVD_W-2:0], ~diff[rcst_pkg::DIVS_W+1]};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_start) begin
            r_div <= i_divisor;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ rtl/rcst_ctrl.sv @@
// Sequencer of the raycaster: setup, sine, march, ceiling and result.
module rcst_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_cast,
    output logic                  o_in_stall,
    input  rcst_pkg::t_dp_status  i_status,
    output rcst_pkg::t_dp_cmd     o_cmd
);
    rcst_pkg::t_state r_state, n_state;
    logic             r_phase, n_phase;

    // Next state
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        case (r_state)
            rcst_pkg::ST_IDLE: begin
                if (i_in_valid && i_in_cast) n_state = rcst_pkg::ST_CT_MUL;
            end
            rcst_pkg::ST_CT_MUL:  n_state = rcst_pkg::ST_CT_DIV;
            rcst_pkg::ST_CT_DIV:  n_state = rcst_pkg::ST_CT_WAIT;
            rcst_pkg::ST_CT_WAIT: begin
                if (i_status.div_done) n_state = rcst_pkg::ST_ANGLE;
            end
            rcst_pkg::ST_ANGLE: begin
                n_phase = 1'b0;
                n_state = rcst_pkg::ST_SZ;
            end
            rcst_pkg::ST_SZ: n_state = rcst_pkg::ST_P1;
            rcst_pkg::ST_P1: n_state = rcst_pkg::ST_P2;
            rcst_pkg::ST_P2: n_state = rcst_pkg::ST_P3;
            rcst_pkg::ST_P3: n_state = rcst_pkg::ST_P4;
            rcst_pkg::ST_P4: n_state = rcst_pkg::ST_P5;
            rcst_pkg::ST_P5: begin
                if (r_phase) begin
                    n_state = rcst_pkg::ST_INC_X;
                end else begin
                    n_phase = 1'b1;
                    n_state = rcst_pkg::ST_SZ;
                end
            end
            rcst_pkg::ST_INC_X: n_state = rcst_pkg::ST_INC_Y;
            rcst_pkg::ST_INC_Y: n_state = rcst_pkg::ST_INIT;
            rcst_pkg::ST_INIT: begin
                n_state = i_status.zero_depth ? rcst_pkg::ST_CL_DIV : rcst_pkg::ST_MARCH;
            end
            rcst_pkg::ST_MARCH: begin
                if (i_status.march_done) n_state = rcst_pkg::ST_CL_DIV;
            end
            rcst_pkg::ST_CL_DIV: n_state = rcst_pkg::ST_CL_WAIT;
            rcst_pkg::ST_CL_WAIT: begin
                if (i_status.div_done) n_state = rcst_pkg::ST_FINISH;
            end
            rcst_pkg::ST_FINISH: begin
                if (i_status.out_free) n_state = rcst_pkg::ST_IDLE;
            end
            default: n_state = rcst_pkg::ST_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_cmd.accept  = (r_state == rcst_pkg::ST_IDLE) && i_in_valid;
        o_cmd.cos_sel = r_phase;
        case (r_state)
            rcst_pkg::ST_CT_MUL: o_cmd.op = rcst_pkg::OP_CT_MUL;
            rcst_pkg::ST_CT_DIV: o_cmd.op = rcst_pkg::OP_CT_DIV;
            rcst_pkg::ST_ANGLE:  o_cmd.op = rcst_pkg::OP_ANGLE;
            rcst_pkg::ST_SZ:     o_cmd.op = rcst_pkg::OP_SZ;
            rcst_pkg::ST_P1:     o_cmd.op = rcst_pkg::OP_P1;
            rcst_pkg::ST_P2:     o_cmd.op = rcst_pkg::OP_P2;
            rcst_pkg::ST_P3:     o_cmd.op = rcst_pkg::OP_P3;
            rcst_pkg::ST_P4:     o_cmd.op = rcst_pkg::OP_P4;
            rcst_pkg::ST_P5:     o_cmd.op = rcst_pkg::OP_P5;
            rcst_pkg::ST_INC_X:  o_cmd.op = rcst_pkg::OP_INC_X;
            rcst_pkg::ST_INC_Y:  o_cmd.op = rcst_pkg::OP_INC_Y;
            rcst_pkg::ST_INIT:   o_cmd.op = rcst_pkg::OP_INIT;
            rcst_pkg::ST_MARCH:  o_cmd.op = rcst_pkg::OP_MARCH;
            rcst_pkg::ST_CL_DIV: o_cmd.op = rcst_pkg::OP_CL_DIV;
            rcst_pkg::ST_FINISH: o_cmd.op = rcst_pkg::OP_FINISH;
            default:             o_cmd.op = rcst_pkg::OP_NONE;
        endcase
    end

    assign o_in_stall = (r_state != rcst_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcst_pkg::ST_IDLE;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    // Input is only taken in idle
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != rcst_pkg::ST_IDLE) |-> o_in_stall)
        else $error("input taken while busy");
    // A cast beat starts the setup sequence
    a_cast_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rcst_pkg::ST_IDLE && i_in_valid && i_in_cast)
        |=> (r_state == rcst_pkg::ST_CT_MUL))
        else $error("cast beat not started");
    // Result is only loaded when the output register can take it
    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rcst_pkg::ST_FINISH && !i_status.out_free)
        |=> (r_state == rcst_pkg::ST_FINISH))
        else $error("finish left without free output");

endmodule

@@ rtl/rcst_dp.sv @@
// Datapath: registers, wall map, shared multiplier, divider and march unit.
module rcst_dp #(
    parameter int MAP_COLS     = 32,
    parameter int MAP_ROWS     = 32,
    parameter int SINE_ENTRIES = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [rcst_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rcst_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  rcst_pkg::t_in_item                   i_in_data,
    input  rcst_pkg::t_dp_cmd                    i_cmd,
    output rcst_pkg::t_dp_status                 o_status,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output rcst_pkg::t_out_item                  o_out_data
);
    localparam int ROW_W = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
    localparam int IDX_W = $clog2(SINE_ENTRIES) + 1;
    localparam int SCL_W = 16 + IDX_W;

    // Configuration registers
    logic [9:0]  r_sw;
    logic [7:0]  r_sh;
    logic [15:0] r_fov;
    logic [21:0] r_max_depth;
    logic [15:0] r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw        <= rcst_pkg::RST_SCREEN_WIDTH;
            r_sh        <= rcst_pkg::RST_SCREEN_HEIGHT;
            r_fov       <= rcst_pkg::RST_FIELD_OF_VIEW;
            r_max_depth <= rcst_pkg::RST_MAX_DEPTH;
            r_step      <= rcst_pkg::RST_MARCH_STEP;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                rcst_pkg::CFG_SCREEN_WIDTH:  r_sw        <= i_cfg_data[9:0];
                rcst_pkg::CFG_SCREEN_HEIGHT: r_sh        <= i_cfg_data[7:0];
                rcst_pkg::CFG_FIELD_OF_VIEW: r_fov       <= i_cfg_data[15:0];
                rcst_pkg::CFG_MAX_DEPTH:     r_max_depth <= i_cfg_data[21:0];
                rcst_pkg::CFG_MARCH_STEP:    r_step      <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Wall map, cleared at reset, written one row per load beat
    logic [31:0] r_map [MAP_ROWS];
    logic [6:0]  wr_row;
    logic        wr_en;

    assign wr_row = 7'(i_in_data.row_index);
    assign wr_en  = i_cmd.accept && (i_in_data.req_type == rcst_pkg::REQ_LOAD)
                    && (int'(i_in_data.row_index) < MAP_ROWS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAP_ROWS; i++) begin
                r_map[i] <= '0;
            end
        end else if (wr_en) begin
            r_map[wr_row[ROW_W-1:0]] <= i_in_data.row_bits;
        end
    end

    // Cast beat fields
    logic [9:0]  r_col;
    logic [20:0] r_px, r_py;
    logic [15:0] r_view;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_col  <= i_in_data.column;
            r_px   <= i_in_data.pos_x;
            r_py   <= i_in_data.pos_y;
            r_view <= i_in_data.view_angle;
        end
    end

    // Divider, shared by the column term and the ceiling
    logic                          div_start;
    logic [rcst_pkg::DIVD_W-1:0]   div_dividend;
    logic [rcst_pkg::DIVS_W-1:0]   div_divisor;
    logic                          div_done;
    logic [rcst_pkg::DIVD_W-1:0]   div_quo;

    logic signed [rcst_pkg::PROD_W-1:0] r_prod;
    logic [rcst_pkg::D_W-1:0]           r_d;

    assign div_start = (i_cmd.op == rcst_pkg::OP_CT_DIV) || (i_cmd.op == rcst_pkg::OP_CL_DIV);
    assign div_dividend = (i_cmd.op == rcst_pkg::OP_CT_DIV)
        ? rcst_pkg::DIVD_W'(r_prod[25:0])
        : {r_sh, 32'd0};
    assign div_divisor = (i_cmd.op == rcst_pkg::OP_CT_DIV)
        ? rcst_pkg::DIVS_W'(r_sw) : r_d;

    rcst_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Ray angle and sine argument
    logic [15:0]      r_angle;
    logic [15:0]      colterm;
    logic [15:0]      a_in;
    logic [SCL_W-1:0] scaled;
    logic [SCL_W-1:0] quant;
    logic [15:0]      a_q;
    logic [16:0]      z0;
    logic [16:0]      r_z;
    logic [1:0]       r_q;
    logic [17:0]      r_z2;

    assign colterm = (r_sw == 10'd0) ? 16'd0 : div_quo[15:0];
    assign a_in    = r_angle + (i_cmd.cos_sel ? 16'd16384 : 16'd0);
    assign scaled  = SCL_W'(a_in) * SCL_W'(SINE_ENTRIES);
    assign quant   = {scaled[SCL_W-1:16], 16'd0} / SCL_W'(SINE_ENTRIES);
    assign a_q     = quant[15:0];
    assign z0      = {1'b0, a_q[13:0], 2'b00};

    // Shared multiplier operand select
    logic signed [17:0] ma, mb;
    logic [17:0]        p_hi;
    logic [17:0]        half;
    logic [15:0]        mag;
    logic [16:0]        step_eff;
    logic signed [15:0] r_ex, r_ey;
    logic signed [31:0] r_incx, r_incy;

    assign p_hi     = r_prod[33:16];
    assign half     = (p_hi + 18'd1) >> 1;
    assign mag      = (half > 18'd32767) ? 16'd32767 : half[15:0];
    assign step_eff = (r_step == 16'd0) ? 17'd1 : {1'b0, r_step};

    always_comb begin
        ma = '0;
        mb = '0;
        case (i_cmd.op)
            rcst_pkg::OP_CT_MUL: begin
                ma = $signed({8'd0, r_col});
                mb = $signed({2'd0, r_fov});
            end
            rcst_pkg::OP_P1: begin
                ma = $signed({1'b0, r_z});
                mb = $signed({1'b0, r_z});
            end
            rcst_pkg::OP_P2: begin
                ma = rcst_pkg::POLY_C;
                mb = $signed(p_hi);
            end
            rcst_pkg::OP_P3: begin
                ma = rcst_pkg::POLY_B - $signed(p_hi);
                mb = $signed(r_z2);
            end
            rcst_pkg::OP_P4: begin
                ma = rcst_pkg::POLY_A - $signed(p_hi);
                mb = $signed({1'b0, r_z});
            end
            rcst_pkg::OP_INC_X: begin
                ma = 18'(r_ex);
                mb = $signed({1'b0, step_eff});
            end
            rcst_pkg::OP_INC_Y: begin
                ma = 18'(r_ey);
                mb = $signed({1'b0, step_eff});
            end
            default: ;
        endcase
    end

    // Multiply, angle, sine and increment registers
    always_ff @(posedge i_clk) begin
        r_prod <= ma * mb;
        case (i_cmd.op)
            rcst_pkg::OP_ANGLE: r_angle <= r_view - {1'b0, r_fov[15:1]} + colterm;
            rcst_pkg::OP_SZ: begin
                r_q <= a_q[15:14];
                r_z <= a_q[14] ? (17'd65536 - z0) : z0;
            end
            rcst_pkg::OP_P2: r_z2 <= p_hi;
            rcst_pkg::OP_P5: begin
                if (i_cmd.cos_sel) begin
                    r_ey <= r_q[1] ? -$signed(mag) : $signed(mag);
                end else begin
                    r_ex <= r_q[1] ? -$signed(mag) : $signed(mag);
                end
            end
            rcst_pkg::OP_INC_Y: r_incx <= r_prod[31:0];
            rcst_pkg::OP_INIT:  r_incy <= r_prod[31:0];
            default: ;
        endcase
    end

    // March: evaluate the current sample, then step or stop
    logic signed [rcst_pkg::ACC_W-1:0] r_sx, r_sy;
    logic                              r_wall;
    logic [8:0]                        cx, cy;
    logic                              out_x, out_y, off_map;
    logic [31:0]                       map_row;
    logic                              wall_cell;
    logic                              d_lt;

    assign cx      = r_sx[39:31];
    assign cy      = r_sy[39:31];
    assign out_x   = cx[8] || (cx[7:0] >= 8'(MAP_COLS));
    assign out_y   = cy[8] || (cy[7:0] >= 8'(MAP_ROWS));
    assign off_map = out_x || out_y;
    assign map_row = r_map[cy[ROW_W-1:0]];
    assign wall_cell = !off_map && (cx[7:5] == 3'd0) && map_row[cx[4:0]];
    assign d_lt    = (r_d < rcst_pkg::D_W'(r_max_depth));

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            rcst_pkg::OP_INIT: begin
                r_sx   <= $signed({4'd0, r_px, 15'd0}) + rcst_pkg::ACC_W'(r_incx);
                r_sy   <= $signed({4'd0, r_py, 15'd0})
                          + rcst_pkg::ACC_W'($signed(r_prod[31:0]));
                r_d    <= (r_max_depth == 22'd0) ? '0 : rcst_pkg::D_W'(step_eff);
                r_wall <= 1'b0;
            end
            rcst_pkg::OP_MARCH: begin
                if (off_map) begin
                    r_d <= rcst_pkg::D_W'(r_max_depth);
                end else if (wall_cell) begin
                    r_wall <= 1'b1;
                end else if (d_lt) begin
                    r_sx <= r_sx + rcst_pkg::ACC_W'(r_incx);
                    r_sy <= r_sy + rcst_pkg::ACC_W'(r_incy);
                    r_d  <= r_d + rcst_pkg::D_W'(step_eff);
                end
            end
            default: ;
        endcase
    end

    // Result: hit, texture side, ceiling and floor rows
    logic               hit;
    logic [15:0]        fx, fy;
    logic signed [16:0] dx, dy;
    logic [16:0]        adx, ady;
    logic               use_y;
    logic signed [41:0] c_val;
    logic signed [7:0]  ceil_row;
    rcst_pkg::t_out_item res;

    assign hit   = r_wall && d_lt;
    assign fx    = r_sx[30:15];
    assign fy    = r_sy[30:15];
    assign dx    = $signed({1'b0, fx}) - 17'sd32768;
    assign dy    = $signed({1'b0, fy}) - 17'sd32768;
    assign adx   = dx[16] ? 17'(-dx) : 17'(dx);
    assign ady   = dy[16] ? 17'(-dy) : 17'(dy);
    assign use_y = (adx > ady) || ((adx == ady) &&
                   ((dx > 0 && dy < 0) || (dx < 0 && dy > 0) || (dx == 0 && dy == 0)));
    assign c_val = $signed({19'd0, r_sh, 15'd0}) - $signed({2'd0, div_quo});

    always_comb begin
        if (r_d == '0) begin
            ceil_row = -8'sd1;
        end else if (!c_val[41]) begin
            ceil_row = $signed(c_val[23:16]);
        end else if (c_val > -42'sd65536) begin
            ceil_row = 8'sd0;
        end else begin
            ceil_row = -8'sd1;
        end
        res.out_column  = r_col;
        res.distance    = r_d[22] ? 22'h3FFFFF : r_d[21:0];
        res.wall_hit    = hit;
        res.ceiling_row = ceil_row;
        res.floor_row   = {1'b0, r_sh} - 9'(ceil_row);
        res.texture_u   = hit ? (use_y ? fy : fx) : 16'd0;
    end

    // Output register
    logic                r_out_valid;
    rcst_pkg::t_out_item r_out;
    logic                out_free;
    logic                out_load;

    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = (i_cmd.op == rcst_pkg::OP_FINISH) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign o_status.div_done   = div_done;
    assign o_status.march_done = off_map || wall_cell || !d_lt;
    assign o_status.zero_depth = (r_max_depth == 22'd0);
    assign o_status.out_free   = out_free;

    // A wall is only reported below max depth
    a_hit_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.wall_hit) |-> (r_out.distance < r_max_depth))
        else $error("wall hit at or past max depth");
    // Floor row follows the screen height and the ceiling row
    a_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.floor_row == ({1'b0, r_sh} - 9'(r_out.ceiling_row))))
        else $error("floor row mismatch");
    // No texture without a hit
    a_tex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.wall_hit) |-> (r_out.texture_u == 16'd0))
        else $error("texture without hit");

endmodule

@@ rtl/tile_map_column_raycaster.sv @@
// A load beat writes one map row. A cast beat runs, from accept to result, two divides (the
// column term and the ceiling), sine and cosine on one shared multiplier, the march and
// the sequencing states; the result then waits in the finish state while the output stalls.
// At most ceil(max_depth/march_step) march steps (1601 by default), 0 for zero max_depth.
// One beat at a time: no new beat is taken until the current cast has loaded its result.
// Reset: synchronous, active low; clears the wall map, loads default registers.
// A finished result waits in the output register while a new beat is taken.
module tile_map_column_raycaster #(
    parameter int MAP_COLS     = 32,
    parameter int MAP_ROWS     = 32,
    parameter int SINE_ENTRIES = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [rcst_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rcst_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  rcst_pkg::t_in_item                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output rcst_pkg::t_out_item               o_out_data
);
    rcst_pkg::t_dp_cmd    cmd;
    rcst_pkg::t_dp_status status;

    rcst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_cast  (i_in_data.req_type == rcst_pkg::REQ_CAST),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rcst_dp #(
        .MAP_COLS     (MAP_COLS),
        .MAP_ROWS     (MAP_ROWS),
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
